// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the block fit allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define BFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bfa_pkg.sv -----
// Package with sizes, codes and control types of the block fit allocator.
`default_nettype none

package bfa_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int LIMIT_W    = $clog2(NUM_BLOCKS + 1);

    // Field widths of the words on the channels.
    localparam int OPCODE_W    = 1;
    localparam int SLOT_W      = 4;
    localparam int ITEM_SIZE_W = 16;
    localparam int BLOCK_W     = 4;

    // Configuration register widths and port shape.
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Widths used for comparisons that mix the fields above.
    localparam int CNT_CMP_W  = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
    localparam int SIZE_CMP_W = (SIZE_BITS > ITEM_SIZE_W) ? SIZE_BITS : ITEM_SIZE_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    // Placement policies.
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // Item opcodes.
    localparam logic [OPCODE_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_REQUEST = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } bfa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_item;
        logic do_load;
        logic scan_issue;
        logic finish;
    } bfa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic scan_none;
        logic scan_last;
        logic out_free;
    } bfa_status_t;

endpackage

`default_nettype wire

// ----- hdl/bfa_if.sv -----
// Valid/ready channel interfaces for request words and result words.
`default_nettype none

interface bfa_req_if import bfa_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [SLOT_W-1:0]      block_slot;
    logic [ITEM_SIZE_W-1:0] item_size;

    modport source (output valid, output opcode, output block_slot, output item_size,
                    input ready);
    modport sink (input valid, input opcode, input block_slot, input item_size,
                  output ready);
endinterface

interface bfa_res_if import bfa_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   granted;
    logic [BLOCK_W-1:0]     chosen_block;
    logic [ITEM_SIZE_W-1:0] chosen_size;

    modport source (output valid, output granted, output chosen_block, output chosen_size,
                    input ready);
    modport sink (input valid, input granted, input chosen_block, input chosen_size,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/bfa_ram.sv -----
// Generic single write port RAM with one registered read port.
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/bfa_ctrl.sv -----
// Controller state machine that sequences loads, scans and result hand-off.
`default_nettype none

module bfa_ctrl import bfa_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire bfa_status_t status,
    output bfa_cmd_t         cmd
);

    bfa_state_t state_reg;
    bfa_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_load)
                begin
                    state_next = ST_LOAD;
                end
                else if (status.scan_none)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.latch_item = in_valid;
            end
            ST_LOAD:
            begin
                cmd.do_load = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/bfa_datapath.sv -----
// Datapath: configuration, size memory, used marks, scan compare and result register.
`default_nettype none

module bfa_datapath import bfa_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [OPCODE_W-1:0]    in_opcode,
    input  wire logic [SLOT_W-1:0]      in_block_slot,
    input  wire logic [ITEM_SIZE_W-1:0] in_item_size,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic                        out_granted,
    output logic [BLOCK_W-1:0]          out_chosen_block,
    output logic [ITEM_SIZE_W-1:0]      out_chosen_size,
    input  wire bfa_cmd_t               cmd,
    output bfa_status_t                 status
);

    logic [MODE_W-1:0]      fit_mode_reg;
    logic [COUNT_W-1:0]     block_count_reg;
    logic [OPCODE_W-1:0]    opcode_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [ITEM_SIZE_W-1:0] size_reg;
    logic [NUM_BLOCKS-1:0]  used_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       pick_reg;
    logic [SIZE_BITS-1:0]   best_reg;
    logic                   res_valid_reg;
    logic                   res_granted_reg;
    logic [BLOCK_W-1:0]     res_block_reg;
    logic [ITEM_SIZE_W-1:0] res_size_reg;

    logic [SIZE_BITS-1:0]   rd_data;
    logic [LIMIT_W-1:0]     limit;
    logic                   slot_ok;
    logic                   is_request;
    logic                   ram_we;
    logic                   fits;
    logic                   better;
    logic                   take;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= MODE_FIRST;
            block_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIT_MODE:    fit_mode_reg    <= cfg_data[MODE_W-1:0];
                REG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                default:         fit_mode_reg    <= fit_mode_reg;
            endcase
        end
    end

    // Accepted word.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            opcode_reg <= in_opcode;
            slot_reg   <= in_block_slot;
            size_reg   <= in_item_size;
        end
    end

    assign is_request = (opcode_reg == OP_REQUEST);
    assign slot_ok    = (int'(slot_reg) < NUM_BLOCKS);

    // Scan length: block count clipped to the table size.
    always_comb
    begin
        if (CNT_CMP_W'(block_count_reg) > CNT_CMP_W'(NUM_BLOCKS))
        begin
            limit = LIMIT_W'(NUM_BLOCKS);
        end
        else
        begin
            limit = LIMIT_W'(block_count_reg);
        end
    end

    // Block size memory, read once per scan step.
    assign ram_we = cmd.do_load && slot_ok;

    bfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(slot_reg)),
        .wdata (SIZE_BITS'(size_reg)),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    // Scan address and read pipeline tag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_issue;
            rd_idx_reg   <= addr_reg;
            if (cmd.latch_item)
            begin
                addr_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
        end
    end

    // Compare the block that was read against the request and the current pick.
    assign fits = !used_reg[rd_idx_reg] &&
                  (SIZE_CMP_W'(rd_data) >= SIZE_CMP_W'(size_reg));

    always_comb
    begin
        better = 1'b0;
        case (fit_mode_reg)
            MODE_BEST:  better = (rd_data < best_reg);
            MODE_WORST: better = (rd_data > best_reg);
            default:    better = 1'b0;
        endcase
    end

    assign take = rd_valid_reg && fits && (!found_reg || better);

    // Running pick of the scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.latch_item)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pick_reg <= rd_idx_reg;
            best_reg <= rd_data;
        end
    end

    // Used marks: a load frees its block, a grant takes the picked block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '1;
        end
        else
        begin
            if (ram_we)
            begin
                used_reg[IDX_W'(slot_reg)] <= 1'b0;
            end
            if (cmd.finish && is_request && found_reg)
            begin
                used_reg[pick_reg] <= 1'b1;
            end
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (is_request && found_reg)
            begin
                res_granted_reg <= 1'b1;
                res_block_reg   <= BLOCK_W'(pick_reg);
                res_size_reg    <= ITEM_SIZE_W'(best_reg);
            end
            else
            begin
                res_granted_reg <= 1'b0;
                res_block_reg   <= '0;
                res_size_reg    <= '0;
            end
        end
    end

    assign out_valid        = res_valid_reg;
    assign out_granted      = res_granted_reg;
    assign out_chosen_block = res_block_reg;
    assign out_chosen_size  = res_size_reg;

    // Status toward the controller.
    always_comb
    begin
        status.is_load   = (opcode_reg == OP_LOAD);
        status.scan_none = !(fit_mode_reg inside {MODE_FIRST, MODE_BEST, MODE_WORST}) ||
                           (limit == '0);
        status.scan_last = ((LIMIT_W'(addr_reg) + LIMIT_W'(1)) == limit);
        status.out_free  = !res_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

// ----- hdl/block_fit_allocator.sv -----
// Top level of the block fit allocator: controller, datapath and assertions.
`default_nettype none
`include "assert_macros.svh"

// Keeps a table of block sizes with a used mark per block; a load word writes
// one size and frees that block, and a request word picks a free block at least
// as large as the request by first, best or worst fit (ties to the lowest index)
// and marks it used. Exactly one result word comes back for every input word.
// The block works on one word at a time: a load passes through the decode, load
// and finish states, and a request through decode, one scan step per block up
// to limit, drain and finish, where limit is block_count clipped to the table
// size; the scan reads the size memory once per scanned block through its
// single read port. A request with an unused policy code or with no blocks skips
// the scan. A new word is accepted while the previous result still waits to be
// taken. After reset every block is used until a load writes it.
module block_fit_allocator import bfa_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    bfa_req_if.sink                    req,
    bfa_res_if.source                  res
);

    bfa_cmd_t    cmd;
    bfa_status_t status;
    logic        in_ready;

    // Sequencing.
    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // Storage, compare and result register.
    bfa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_opcode        (req.opcode),
        .in_block_slot    (req.block_slot),
        .in_item_size     (req.item_size),
        .out_ready        (res.ready),
        .out_valid        (res.valid),
        .out_granted      (res.granted),
        .out_chosen_block (res.chosen_block),
        .out_chosen_size  (res.chosen_size),
        .cmd              (cmd),
        .status           (status)
    );

    // Only one word is in work at a time.
    `BFA_ASSERT_NEXT(a_one_word, clk, rst_n, req.valid && req.ready, !req.ready, "second word accepted while busy")

    // A scan step never overlaps with acceptance.
    `BFA_ASSERT_SAME(a_scan_busy, clk, rst_n, cmd.scan_issue, !req.ready, "ready high during scan")

    // A finished word shows up on the output in the next cycle.
    `BFA_ASSERT_NEXT(a_finish_shown, clk, rst_n, cmd.finish, res.valid, "finished result not presented")

    // A result that grants nothing carries zero index and size.
    `BFA_ASSERT_SAME(a_reject_zero, clk, rst_n, res.valid && !res.granted, res.chosen_block == '0 && res.chosen_size == '0, "non-granted result not zero")

endmodule

`default_nettype wire
